FILE: src/mrpp_pkg.sv
`default_nettype none

package mrpp_pkg;

   // Field widths
   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned KIND_W  = 3;
   localparam int unsigned LEN_W   = 28;
   localparam int unsigned TOPIC_W = 16;
   localparam int unsigned DIGIT_W = 3;

   // Default cap on remaining length bytes
   localparam int unsigned MAX_LENGTH_DIGITS_DEFAULT = 4;

   // Packet type codes (high nibble of the fixed header)
   localparam logic [3:0] TYPE_CONNACK = 4'd2;
   localparam logic [3:0] TYPE_PUBLISH = 4'd3;
   localparam logic [3:0] TYPE_SUBACK  = 4'd9;

   // Parser phases
   typedef enum logic [2:0] {
      PH_HEADER   = 3'd0,
      PH_LENGTH   = 3'd1,
      PH_TOPIC_HI = 3'd2,
      PH_TOPIC_LO = 3'd3,
      PH_TOPIC    = 3'd4,
      PH_PKTID    = 3'd5,
      PH_PAYLOAD  = 3'd6,
      PH_SKIP     = 3'd7
   } phase_type;

   // Result event codes
   typedef enum logic [KIND_W-1:0] {
      EV_PAYLOAD   = 3'd0,
      EV_CONNACK   = 3'd1,
      EV_SUBACK    = 3'd2,
      EV_EMPTY     = 3'd3,
      EV_MALFORMED = 3'd4
   } event_type;

endpackage

`default_nettype wire

FILE: src/mrpp_req_if.sv
`default_nettype none

// Received byte stream channel
interface mrpp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

FILE: src/mrpp_rsp_if.sv
`default_nettype none

// Parser event channel
interface mrpp_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] event_kind;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output event_kind, output data_byte, output last_byte,
                   input ready);
   modport sink   (input valid, input event_kind, input data_byte, input last_byte,
                   output ready);
endinterface

`default_nettype wire

FILE: src/mqtt_receive_packet_parser_top.sv
`default_nettype none

// Channel    | Dir | Payload                                | Handshake
// req_chan   | in  | rx_byte[7:0]                           | valid/ready
// rsp_chan   | out | event_kind[2:0] data_byte[7:0] last_byte | valid/ready
//
// One byte is taken per cycle unless req_chan is stalled; its event, if any, appears on rsp_chan
// the next cycle from the result register. The framing state and the result register are
// the only storage, so throughput is one byte per clock with no gaps between packets while unstalled.
// req_chan is stalled only while a result waits in the register and rsp_chan is stalled.
// Synchronous reset returns the parser to waiting for a header byte and drops any result.

module mqtt_receive_packet_parser_top #(
   parameter int unsigned MAX_LENGTH_DIGITS = mrpp_pkg::MAX_LENGTH_DIGITS_DEFAULT
) (
   input  wire         clock,
   input  wire         reset,
   mrpp_req_if.sink    req_chan,
   mrpp_rsp_if.source  rsp_chan
);

   import mrpp_pkg::*;

   localparam logic [DIGIT_W-1:0] MaxDigits = DIGIT_W'(MAX_LENGTH_DIGITS);

   // Framing state
   phase_type             phase_ff,  phase_in;
   logic [3:0]            ptype_ff,  ptype_in;
   logic                  qos_ff,    qos_in;
   logic [LEN_W-1:0]      accum_ff,  accum_in;
   logic [DIGIT_W-1:0]    digits_ff, digits_in;
   logic [LEN_W-1:0]      left_ff,   left_in;
   logic [TOPIC_W-1:0]    topic_ff,  topic_in;
   logic [1:0]            bidx_ff,   bidx_in;

   // Result register
   logic                  rvalid_ff;
   event_type             kind_ff;
   logic [BYTE_W-1:0]     data_ff;
   logic                  last_ff;

   // Event produced by the current beat
   logic                  emit;
   event_type             kind_in;
   logic [BYTE_W-1:0]     data_in;
   logic                  last_in;

   logic                  fire;
   logic [BYTE_W-1:0]     b;
   logic [LEN_W-1:0]      left_dec;
   logic [LEN_W-1:0]      digit_term;
   logic [LEN_W-1:0]      accum_sum;
   logic [TOPIC_W:0]      need;

   assign fire           = req_chan.valid && req_chan.ready;
   assign req_chan.ready = !rvalid_ff || rsp_chan.ready;
   assign b              = req_chan.rx_byte;
   assign left_dec       = left_ff - LEN_W'(1);

   // Place the 7 length bits at their base-128 weight
   always_comb begin
      case (digits_ff[1:0])
         2'd0:    digit_term = {21'd0, b[6:0]};
         2'd1:    digit_term = {14'd0, b[6:0], 7'd0};
         2'd2:    digit_term = {7'd0, b[6:0], 14'd0};
         default: digit_term = {b[6:0], 21'd0};
      endcase
   end
   assign accum_sum = accum_ff + digit_term;

   // Topic plus optional packet id must fit in what is left
   assign need = {1'b0, topic_ff[15:8], b} + (qos_ff ? (TOPIC_W+1)'(2) : '0);

   // Next state and event for one beat
   always_comb begin
      phase_in  = phase_ff;
      ptype_in  = ptype_ff;
      qos_in    = qos_ff;
      accum_in  = accum_ff;
      digits_in = digits_ff;
      left_in   = left_ff;
      topic_in  = topic_ff;
      bidx_in   = bidx_ff;
      emit      = 1'b0;
      kind_in   = EV_PAYLOAD;
      data_in   = '0;
      last_in   = 1'b0;

      case (phase_ff)
         PH_HEADER: begin
            ptype_in  = b[7:4];
            qos_in    = |b[2:1];
            accum_in  = '0;
            digits_in = '0;
            phase_in  = PH_LENGTH;
         end

         PH_LENGTH: begin
            if (digits_ff >= MaxDigits) begin
               phase_in = PH_HEADER;
               emit     = 1'b1;
               kind_in  = EV_MALFORMED;
            end else begin
               accum_in  = accum_sum;
               digits_in = digits_ff + DIGIT_W'(1);
               if (!b[7]) begin
                  left_in = accum_sum;
                  bidx_in = '0;
                  if (ptype_ff == TYPE_PUBLISH) begin
                     if (accum_sum == '0) begin
                        phase_in = PH_HEADER;
                        emit     = 1'b1;
                        kind_in  = EV_MALFORMED;
                     end else begin
                        phase_in = PH_TOPIC_HI;
                     end
                  end else begin
                     phase_in = (accum_sum == '0) ? PH_HEADER : PH_SKIP;
                  end
               end
            end
         end

         PH_TOPIC_HI: begin
            left_in  = left_dec;
            topic_in = {b, 8'd0};
            if (left_dec == '0) begin
               phase_in = PH_HEADER;
               emit     = 1'b1;
               kind_in  = EV_MALFORMED;
            end else begin
               phase_in = PH_TOPIC_LO;
            end
         end

         PH_TOPIC_LO: begin
            left_in  = left_dec;
            topic_in = {topic_ff[15:8], b};
            if (LEN_W'(need) > left_dec) begin
               // overrun: flag once, drop the rest of the packet
               bidx_in  = 2'd3;
               phase_in = (left_dec == '0) ? PH_HEADER : PH_SKIP;
               emit     = 1'b1;
               kind_in  = EV_MALFORMED;
            end else if ({topic_ff[15:8], b} != '0) begin
               phase_in = PH_TOPIC;
            end else if (qos_ff) begin
               bidx_in  = '0;
               phase_in = PH_PKTID;
            end else if (left_dec == '0) begin
               phase_in = PH_HEADER;
               emit     = 1'b1;
               kind_in  = EV_EMPTY;
            end else begin
               phase_in = PH_PAYLOAD;
            end
         end

         PH_TOPIC: begin
            left_in  = left_dec;
            topic_in = topic_ff - TOPIC_W'(1);
            if (topic_ff == TOPIC_W'(1)) begin
               if (qos_ff) begin
                  bidx_in  = '0;
                  phase_in = PH_PKTID;
               end else if (left_dec == '0) begin
                  phase_in = PH_HEADER;
                  emit     = 1'b1;
                  kind_in  = EV_EMPTY;
               end else begin
                  phase_in = PH_PAYLOAD;
               end
            end
         end

         PH_PKTID: begin
            left_in = left_dec;
            if (bidx_ff == 2'd0) begin
               bidx_in = 2'd1;
            end else begin
               bidx_in = 2'd2;
               if (left_dec == '0) begin
                  phase_in = PH_HEADER;
                  emit     = 1'b1;
                  kind_in  = EV_EMPTY;
               end else begin
                  phase_in = PH_PAYLOAD;
               end
            end
         end

         PH_PAYLOAD: begin
            left_in = left_dec;
            emit    = 1'b1;
            kind_in = EV_PAYLOAD;
            data_in = b;
            if (left_dec == '0) begin
               phase_in = PH_HEADER;
               last_in  = 1'b1;
            end
         end

         default: begin
            // skip body, picking out ack return codes
            left_in = left_dec;
            if (bidx_ff != 2'd3) begin
               bidx_in = bidx_ff + 2'd1;
            end
            if (ptype_ff == TYPE_CONNACK && bidx_ff == 2'd1) begin
               emit    = 1'b1;
               kind_in = EV_CONNACK;
               data_in = b;
            end else if (ptype_ff == TYPE_SUBACK && bidx_ff == 2'd2) begin
               emit    = 1'b1;
               kind_in = EV_SUBACK;
               data_in = b;
            end
            if (left_dec == '0) begin
               phase_in = PH_HEADER;
            end
         end
      endcase
   end

   // State update on each accepted beat
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HEADER;
         ptype_ff  <= '0;
         qos_ff    <= 1'b0;
         accum_ff  <= '0;
         digits_ff <= '0;
         left_ff   <= '0;
         topic_ff  <= '0;
         bidx_ff   <= '0;
      end else if (fire) begin
         phase_ff  <= phase_in;
         ptype_ff  <= ptype_in;
         qos_ff    <= qos_in;
         accum_ff  <= accum_in;
         digits_ff <= digits_in;
         left_ff   <= left_in;
         topic_ff  <= topic_in;
         bidx_ff   <= bidx_in;
      end
   end

   // Result register valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rvalid_ff <= 1'b0;
      end else if (fire) begin
         rvalid_ff <= emit;
      end else if (rsp_chan.ready) begin
         rvalid_ff <= 1'b0;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (fire && emit) begin
         kind_ff <= kind_in;
         data_ff <= data_in;
         last_ff <= last_in;
      end
   end

   assign rsp_chan.valid      = rvalid_ff;
   assign rsp_chan.event_kind = kind_ff;
   assign rsp_chan.data_byte  = data_ff;
   assign rsp_chan.last_byte  = last_ff;

endmodule

`default_nettype wire
